[rtl/core/wbss_pkg.sv]
`timescale 1ns / 1ps

package wbss_pkg;

  localparam int MAX_POINTS        = 1048576;
  localparam int MAX_LENGTH_DIGITS = 9;
  localparam int QUEUE_DEPTH       = 4;

  localparam int CNT_W = 21;
  localparam int LEN_W = 30;
  localparam int IDX_W = 20;
  localparam int RAW_W = 17;

  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_1    = 8'h31;
  localparam logic [7:0] CH_9    = 8'h39;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_NDIG_MAX = 8'(32'(CH_0) + MAX_LENGTH_DIGITS);

  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_DONE   = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_NO_HASH   = 3'd1;
  localparam logic [2:0] ERR_DIGIT_CNT = 3'd2;
  localparam logic [2:0] ERR_NON_DIGIT = 3'd3;
  localparam logic [2:0] ERR_LENGTH    = 3'd4;
  localparam logic [2:0] ERR_NO_LF     = 3'd5;

  localparam logic [2:0] REG_BPP         = 3'd0;
  localparam logic [2:0] REG_MSB_FIRST   = 3'd1;
  localparam logic [2:0] REG_SIGNED      = 3'd2;
  localparam logic [2:0] REG_POINT_COUNT = 3'd3;
  localparam logic [2:0] REG_Y_MULT      = 3'd4;
  localparam logic [2:0] REG_Y_ZERO      = 3'd5;
  localparam logic [2:0] REG_Y_OFFSET    = 3'd6;
  localparam logic [2:0] REG_X_INCREMENT = 3'd7;

  typedef enum logic [2:0] {
    PH_HASH,
    PH_NDIG,
    PH_LEN,
    PH_DATA,
    PH_NL
  } phase_t;

  typedef struct packed {
    logic [1:0]       bytes_per_point;
    logic             msb_first;
    logic             signed_samples;
    logic [CNT_W-1:0] point_count;
    logic [47:0]      y_mult;
    logic [47:0]      y_zero;
    logic [31:0]      y_offset;
    logic [47:0]      x_increment;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    bytes_per_point: 2'd1,
    msb_first:       1'b0,
    signed_samples:  1'b1,
    point_count:     21'd1,
    y_mult:          48'h0001_0000_0000,
    y_zero:          48'd0,
    y_offset:        32'd0,
    x_increment:     48'd0
  };

  typedef struct packed {
    logic [1:0]              kind;
    logic [2:0]              code;
    logic [IDX_W-1:0]        index;
    logic signed [RAW_W-1:0] raw;
    logic [63:0]             x;
  } job_t;

endpackage

[rtl/core/wbss_front.sv]
`timescale 1ns / 1ps

module wbss_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [7:0]     byte_in,
  input  wbss_pkg::cfg_t cfg,
  input  logic           q_full,
  output logic           push,
  output wbss_pkg::job_t push_job
);
  import wbss_pkg::*;

  phase_t           phase, phase_next;
  logic [3:0]       digits_left, digits_left_next;
  logic [LEN_W-1:0] declared_length, declared_length_next;
  logic [7:0]       first_byte, first_byte_next;
  logic             byte_position, byte_position_next;
  logic [CNT_W-1:0] point_index, point_index_next;
  logic [63:0]      time_acc, time_acc_next;

  logic             accept;
  logic             fail;
  logic [2:0]       fail_code;
  logic             bpp2;
  logic [CNT_W-1:0] cnt;
  logic [LEN_W-1:0] expected;
  logic [LEN_W-1:0] len_acc;
  logic [15:0]      raw16;
  logic [RAW_W-1:0] sample;
  logic [64:0]      tsum;
  logic [CNT_W:0]   idx_inc;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign bpp2     = (cfg.bytes_per_point == 2'd2);
  assign cnt      = (32'(cfg.point_count) > MAX_POINTS) ? CNT_W'(MAX_POINTS) : cfg.point_count;
  assign expected = bpp2 ? LEN_W'({cnt, 1'b0}) : LEN_W'(cnt);
  assign len_acc  = (declared_length << 3) + (declared_length << 1) + LEN_W'(byte_in[3:0]);
  assign raw16    = cfg.msb_first ? {first_byte, byte_in} : {byte_in, first_byte};
  assign tsum     = {1'b0, time_acc} + {17'd0, cfg.x_increment};
  assign idx_inc  = {1'b0, point_index} + 1'b1;

  always_comb begin
    if (bpp2) begin
      sample = (cfg.signed_samples && raw16[15]) ? {1'b1, raw16} : {1'b0, raw16};
    end else begin
      sample = (cfg.signed_samples && byte_in[7]) ? {9'h1FF, byte_in} : {9'h000, byte_in};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HASH;
      digits_left     <= '0;
      declared_length <= '0;
      first_byte      <= '0;
      byte_position   <= 1'b0;
      point_index     <= '0;
      time_acc        <= '0;
    end else begin
      phase           <= phase_next;
      digits_left     <= digits_left_next;
      declared_length <= declared_length_next;
      first_byte      <= first_byte_next;
      byte_position   <= byte_position_next;
      point_index     <= point_index_next;
      time_acc        <= time_acc_next;
    end
  end

  always_comb begin
    phase_next           = phase;
    digits_left_next     = digits_left;
    declared_length_next = declared_length;
    first_byte_next      = first_byte;
    byte_position_next   = byte_position;
    point_index_next     = point_index;
    time_acc_next        = time_acc;
    fail                 = 1'b0;
    fail_code            = ERR_NONE;
    push                 = 1'b0;
    push_job             = '0;

    if (accept) begin
      unique case (phase)
        PH_HASH: begin
          if (byte_in != CH_HASH) begin
            fail      = 1'b1;
            fail_code = ERR_NO_HASH;
          end else begin
            phase_next = PH_NDIG;
          end
        end
        PH_NDIG: begin
          if (byte_in < CH_1 || byte_in > CH_NDIG_MAX) begin
            fail      = 1'b1;
            fail_code = ERR_DIGIT_CNT;
          end else begin
            digits_left_next     = byte_in[3:0];
            declared_length_next = '0;
            phase_next           = PH_LEN;
          end
        end
        PH_LEN: begin
          if (byte_in < CH_0 || byte_in > CH_9) begin
            fail      = 1'b1;
            fail_code = ERR_NON_DIGIT;
          end else begin
            declared_length_next = len_acc;
            digits_left_next     = digits_left - 1'b1;
            if (digits_left == 4'd1) begin
              if (len_acc != expected) begin
                fail      = 1'b1;
                fail_code = ERR_LENGTH;
              end else begin
                point_index_next   = '0;
                byte_position_next = 1'b0;
                time_acc_next      = '0;
                phase_next         = (cnt == '0) ? PH_NL : PH_DATA;
              end
            end
          end
        end
        PH_DATA: begin
          if (bpp2 && !byte_position) begin
            first_byte_next    = byte_in;
            byte_position_next = 1'b1;
          end else begin
            byte_position_next = 1'b0;
            push               = 1'b1;
            push_job.kind      = KIND_SAMPLE;
            push_job.code      = ERR_NONE;
            push_job.index     = point_index[IDX_W-1:0];
            push_job.raw       = sample;
            push_job.x         = time_acc;
            time_acc_next      = tsum[64] ? '1 : tsum[63:0];
            point_index_next   = idx_inc[CNT_W-1:0];
            if (idx_inc >= {1'b0, cnt}) begin
              phase_next = PH_NL;
            end
          end
        end
        PH_NL: begin
          if (byte_in != CH_LF) begin
            fail      = 1'b1;
            fail_code = ERR_NO_LF;
          end else begin
            phase_next           = PH_HASH;
            digits_left_next     = '0;
            declared_length_next = '0;
            first_byte_next      = '0;
            byte_position_next   = 1'b0;
            point_index_next     = '0;
            time_acc_next        = '0;
            push                 = 1'b1;
            push_job.kind        = KIND_DONE;
          end
        end
        default: begin
          phase_next           = PH_HASH;
          digits_left_next     = '0;
          declared_length_next = '0;
          first_byte_next      = '0;
          byte_position_next   = 1'b0;
          point_index_next     = '0;
          time_acc_next        = '0;
        end
      endcase

      if (fail) begin
        phase_next           = PH_HASH;
        digits_left_next     = '0;
        declared_length_next = '0;
        first_byte_next      = '0;
        byte_position_next   = 1'b0;
        point_index_next     = '0;
        time_acc_next        = '0;
        push                 = 1'b1;
        push_job             = '0;
        push_job.kind        = KIND_ERROR;
        push_job.code        = fail_code;
      end
    end
  end

endmodule

[rtl/core/wbss_fifo.sv]
`timescale 1ns / 1ps

module wbss_fifo #(
  parameter int DEPTH = wbss_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  wbss_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output wbss_pkg::job_t head
);
  import wbss_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  job_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_job;
    end
  end

endmodule

[rtl/core/wbss_back.sv]
`timescale 1ns / 1ps

module wbss_back (
  input  logic           clk,
  input  logic           rst,
  input  wbss_pkg::cfg_t cfg,
  input  logic           q_empty,
  input  wbss_pkg::job_t head,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output wbss_pkg::job_t out_job,
  output logic [63:0]    out_y
);
  import wbss_pkg::*;

  logic               en;
  logic               s1_valid, s2_valid, s3_valid;
  job_t               s1_job, s2_job, s3_job;
  logic signed [33:0] diff_c, s1_diff;
  logic signed [58:0] pl_c, s2_pl;
  logic signed [57:0] ph_c, s2_ph;
  logic signed [81:0] prod_c, s3_prod;
  logic signed [66:0] ysum;
  logic [63:0]        ysat;

  assign en  = !out_valid || out_ready;
  assign pop = en && !q_empty;

  // Stage one forms sample * 2^16 - y_offset, stage two the two partial products,
  // stage three their sum, stage four the floor shift, the y_zero add and saturation.
  assign diff_c = $signed({head.raw[RAW_W-1], head.raw, 16'd0})
                - $signed({{2{cfg.y_offset[31]}}, cfg.y_offset});
  assign pl_c   = $signed({1'b0, cfg.y_mult[23:0]}) * s1_diff;
  assign ph_c   = $signed(cfg.y_mult[47:24]) * s1_diff;
  assign prod_c = $signed({s2_ph, 24'd0}) + $signed({{23{s2_pl[58]}}, s2_pl});
  assign ysum   = $signed({s3_prod[81], s3_prod[81:16]})
                + $signed({{19{cfg.y_zero[47]}}, cfg.y_zero});

  always_comb begin
    if (ysum[66:63] == 4'b0000 || ysum[66:63] == 4'b1111) begin
      ysat = ysum[63:0];
    end else if (ysum[66]) begin
      ysat = 64'h8000_0000_0000_0000;
    end else begin
      ysat = 64'h7FFF_FFFF_FFFF_FFFF;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s1_valid  <= !q_empty;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_job  <= head;
      s1_diff <= diff_c;
      s2_job  <= s1_job;
      s2_pl   <= pl_c;
      s2_ph   <= ph_c;
      s3_job  <= s2_job;
      s3_prod <= prod_c;
      out_job <= s3_job;
      out_y   <= (s3_job.kind == KIND_SAMPLE) ? ysat : 64'd0;
    end
  end

  a_sample_code : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_job.kind == KIND_SAMPLE |-> out_job.code == ERR_NONE)
    else $error("sample result carries an error code");

  a_status_zero : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_job.kind != KIND_SAMPLE
      |-> out_y == 64'd0 && out_job.x == 64'd0 && out_job.raw == '0 && out_job.index == '0)
    else $error("status result carries sample fields");

  a_pipe_hold : assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(s3_valid) && $stable(s1_valid) && (!s3_valid || $stable(s3_prod)))
    else $error("scale pipeline moved while the output was stalled");

endmodule

[rtl/core/waveform_block_sample_scaler.sv]
`timescale 1ns / 1ps

// A completing byte passes the queue, s1, s2, s3 and out_valid. One byte per cycle
// is taken while the queue is not full; the four-stage scale pipeline takes one
// result per cycle unless the output stalls; a QUEUE_DEPTH-entry queue sits between
// parser and pipeline. Reset (rst, synchronous, active high) clears parser state,
// queue and pipeline, and loads every configuration register with its default value.
module waveform_block_sample_scaler #(
  parameter int QUEUE_DEPTH = wbss_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [7:0]    s_axis_tdata,   // byte_in
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // error_code, sample_index, raw_sample, x_value, y_value
  output logic [167:0]  m_axis_tdata,
  output logic [1:0]    m_axis_tuser,   // result_kind
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [47:0]   cfg_data
);
  import wbss_pkg::*;

  cfg_t        cfg;
  logic        push;
  job_t        push_job;
  logic        q_full;
  logic        q_empty;
  logic        pop;
  job_t        head;
  job_t        out_job;
  logic [63:0] out_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BPP:         cfg.bytes_per_point <= cfg_data[1:0];
        REG_MSB_FIRST:   cfg.msb_first       <= cfg_data[0];
        REG_SIGNED:      cfg.signed_samples  <= cfg_data[0];
        REG_POINT_COUNT: cfg.point_count     <= cfg_data[CNT_W-1:0];
        REG_Y_MULT:      cfg.y_mult          <= cfg_data;
        REG_Y_ZERO:      cfg.y_zero          <= cfg_data;
        REG_Y_OFFSET:    cfg.y_offset        <= cfg_data[31:0];
        REG_X_INCREMENT: cfg.x_increment     <= cfg_data;
        default: ;
      endcase
    end
  end

  wbss_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .byte_in  (s_axis_tdata),
    .cfg      (cfg),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  wbss_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .empty    (q_empty),
    .head     (head)
  );

  wbss_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .head      (head),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_job   (out_job),
    .out_y     (out_y)
  );

  assign m_axis_tuser = out_job.kind;
  assign m_axis_tdata = {out_y, out_job.x, out_job.raw, out_job.index, out_job.code};

endmodule

[tb/sv/waveform_block_sample_scaler_tb.sv]
`timescale 1ns / 1ps

module waveform_block_sample_scaler_tb;
  import wbss_pkg::*;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [63:0] y;
    logic [63:0]        x;
    logic signed [16:0] raw;
    logic [19:0]        index;
    logic [2:0]         code;
  } curve_result_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  wire          s_axis_tready;
  logic [7:0]   s_axis_tdata = '0;
  wire          m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  wire  [167:0] m_axis_tdata;
  wire  [1:0]   m_axis_tuser;
  logic         cfg_we = 1'b0;
  logic [2:0]   cfg_index = '0;
  logic [47:0]  cfg_data = '0;

  logic [7:0]    curve_bytes[$];
  curve_result_t due_results[$];
  int            bytes_queued = 0;
  int            mismatch_count = 0;
  int            idle_pct = 0;
  int            stall_pct = 0;

  cfg_t        scaler_cfg = CFG_RESET;
  phase_t      parse_phase = PH_HASH;
  logic [3:0]  digits_left = '0;
  int unsigned declared_len = 0;
  logic [7:0]  first_byte = '0;
  logic        byte_pos = 1'b0;
  logic [20:0] point_idx = '0;
  logic [63:0] time_acc = '0;

  waveform_block_sample_scaler dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int unsigned active_points();
    return (scaler_cfg.point_count > MAX_POINTS) ? MAX_POINTS : scaler_cfg.point_count;
  endfunction

  function automatic int unsigned bytes_per_sample();
    return (scaler_cfg.bytes_per_point == 2'd2) ? 2 : 1;
  endfunction

  function automatic logic [63:0] scaled_y(input logic signed [16:0] s);
    logic signed [127:0] mult, diff, sum;
    mult = $signed(scaler_cfg.y_mult);
    diff = s;
    diff = (diff <<< 16) - $signed(scaler_cfg.y_offset);
    sum = ((mult * diff) >>> 16) + $signed(scaler_cfg.y_zero);
    if (&sum[127:63] || ~|sum[127:63]) return sum[63:0];
    return sum[127] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
  endfunction

  task automatic clear_block();
    parse_phase = PH_HASH;
    digits_left = '0;
    declared_len = 0;
    first_byte = '0;
    byte_pos = 1'b0;
    point_idx = '0;
    time_acc = '0;
  endtask

  task automatic post_status(input logic [1:0] kind, input logic [2:0] code);
    curve_result_t r;
    r = '0;
    r.kind = kind;
    r.code = code;
    clear_block();
    due_results.push_back(r);
  endtask

  task automatic parse_curve_byte(input logic [7:0] b);
    curve_result_t r;
    logic [15:0] word;
    logic signed [16:0] s;
    logic [64:0] nxt;
    case (parse_phase)
      PH_HASH: begin
        if (b != CH_HASH) post_status(KIND_ERROR, ERR_NO_HASH);
        else parse_phase = PH_NDIG;
      end
      PH_NDIG: begin
        if (b < CH_1 || b > CH_NDIG_MAX) begin
          post_status(KIND_ERROR, ERR_DIGIT_CNT);
        end else begin
          digits_left = 4'(b - CH_0);
          declared_len = 0;
          parse_phase = PH_LEN;
        end
      end
      PH_LEN: begin
        if (b < CH_0 || b > CH_9) begin
          post_status(KIND_ERROR, ERR_NON_DIGIT);
        end else begin
          declared_len = declared_len * 10 + (b - CH_0);
          digits_left = digits_left - 1'b1;
          if (digits_left == 0) begin
            if (declared_len != bytes_per_sample() * active_points()) begin
              post_status(KIND_ERROR, ERR_LENGTH);
            end else begin
              point_idx = '0;
              byte_pos = 1'b0;
              time_acc = '0;
              parse_phase = (active_points() == 0) ? PH_NL : PH_DATA;
            end
          end
        end
      end
      PH_DATA: begin
        if (bytes_per_sample() == 2 && !byte_pos) begin
          first_byte = b;
          byte_pos = 1'b1;
        end else begin
          if (bytes_per_sample() == 2) begin
            word = scaler_cfg.msb_first ? {first_byte, b} : {b, first_byte};
            s = scaler_cfg.signed_samples ? {word[15], word} : {1'b0, word};
          end else begin
            s = scaler_cfg.signed_samples ? {{9{b[7]}}, b} : {9'd0, b};
          end
          byte_pos = 1'b0;
          r.kind = KIND_SAMPLE;
          r.code = ERR_NONE;
          r.index = point_idx[19:0];
          r.raw = s;
          r.x = time_acc;
          r.y = scaled_y(s);
          due_results.push_back(r);
          nxt = {1'b0, time_acc} + scaler_cfg.x_increment;
          time_acc = nxt[64] ? '1 : nxt[63:0];
          point_idx = point_idx + 1'b1;
          if (point_idx >= active_points()) parse_phase = PH_NL;
        end
      end
      PH_NL: begin
        if (b != CH_LF) post_status(KIND_ERROR, ERR_NO_LF);
        else post_status(KIND_DONE, ERR_NONE);
      end
      default: clear_block();
    endcase
  endtask

  task automatic check_result(input curve_result_t got);
    curve_result_t want;
    if (due_results.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("unexpected result: kind %0d code %0d index %0d raw %0d x %h y %h",
                 got.kind, got.code, got.index, got.raw, got.x, got.y);
    end else begin
      want = due_results.pop_front();
      if (got.kind !== want.kind || got.code !== want.code || got.index !== want.index ||
          got.raw !== want.raw || got.x !== want.x || got.y !== want.y) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("mismatch: want kind %0d code %0d index %0d raw %0d x %h y %h",
                   want.kind, want.code, want.index, want.raw, want.x, want.y);
          $display("          got  kind %0d code %0d index %0d raw %0d x %h y %h",
                   got.kind, got.code, got.index, got.raw, got.x, got.y);
        end
      end
    end
  endtask

  // A new request is offered only once the previous one has been taken.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) parse_curve_byte(s_axis_tdata);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (curve_bytes.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          s_axis_tdata <= curve_bytes.pop_front();
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_result({m_axis_tuser, m_axis_tdata});
      m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic push_byte(input logic [7:0] b);
    curve_bytes.push_back(b);
    bytes_queued++;
  endtask

  task automatic push_text(input string t);
    for (int i = 0; i < t.len(); i++) push_byte(t[i]);
  endtask

  function automatic int unsigned digits_for(input int unsigned v);
    int unsigned n;
    n = 1;
    while (v >= 10) begin
      v /= 10;
      n++;
    end
    return n;
  endfunction

  task automatic push_header(input int unsigned len, input int unsigned nd);
    int unsigned p;
    p = 1;
    for (int i = 1; i < nd; i++) p *= 10;
    push_byte(CH_HASH);
    push_byte(8'(CH_0 + nd));
    for (int i = 0; i < nd; i++) begin
      push_byte(8'(CH_0 + (len / p) % 10));
      p /= 10;
    end
  endtask

  function automatic logic [7:0] data_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h7F;
      3: return 8'h80;
      default: return 8'($urandom);
    endcase
  endfunction

  // Mostly complete blocks; the rest are stray bytes and blocks broken at each step.
  task automatic push_random_block();
    int unsigned len, nd, pick;
    logic [7:0] b;
    len = bytes_per_sample() * active_points();
    nd = $urandom_range(digits_for(len), MAX_LENGTH_DIGITS);
    pick = $urandom_range(0, 99);
    if (pick < 72 || pick >= 93) begin
      push_header(len, nd);
      repeat (len) push_byte(data_byte());
      if (pick < 72) begin
        push_byte(CH_LF);
      end else begin
        do b = 8'($urandom); while (b == CH_LF);
        push_byte(b);
      end
    end else if (pick < 76) begin
      repeat ($urandom_range(1, 3)) begin
        do b = 8'($urandom); while (b == CH_HASH);
        push_byte(b);
      end
    end else if (pick < 81) begin
      push_byte(CH_HASH);
      if ($urandom_range(0, 1)) begin
        b = CH_0;
      end else begin
        do b = 8'($urandom); while (b >= CH_1 && b <= CH_NDIG_MAX);
      end
      push_byte(b);
    end else if (pick < 86) begin
      push_byte(CH_HASH);
      push_byte(8'(CH_0 + nd));
      repeat ($urandom_range(0, nd - 1)) push_byte(8'(CH_0 + $urandom_range(0, 9)));
      do b = 8'($urandom); while (b >= CH_0 && b <= CH_9);
      push_byte(b);
    end else begin
      len = (len > 0 && $urandom_range(0, 1)) ? len - 1 : len + $urandom_range(1, 20);
      push_header(len, $urandom_range(digits_for(len), MAX_LENGTH_DIGITS));
    end
  endtask

  function automatic logic [47:0] pick_wide(input int mode);
    logic [32:0] r;
    r = {1'($urandom), $urandom};
    case (mode)
      0: return 48'h7FFF_FFFF_FFFF;
      1: return 48'h8000_0000_0000;
      2: return '0;
      3: return {16'($urandom), $urandom};
      4: return '1;
      default: return {{15{r[32]}}, r};
    endcase
  endfunction

  function automatic cfg_t make_cfg(input int k);
    cfg_t c;
    logic [31:0] off;
    off = $urandom;
    c.bytes_per_point = (k < 4) ? 2'(k) :
                        ($urandom_range(0, 1) ? 2'd2 : 2'($urandom_range(0, 3)));
    c.msb_first = 1'($urandom);
    c.signed_samples = 1'($urandom);
    c.point_count = (k == 3) ? '0 : CNT_W'($urandom_range(1, 6));
    c.y_mult = pick_wide((k < 2) ? k : $urandom_range(2, 7));
    c.y_zero = pick_wide((k < 2) ? k : $urandom_range(2, 7));
    c.x_increment = pick_wide((k == 0) ? 4 : $urandom_range(2, 7));
    case ($urandom_range(0, 3))
      0: c.y_offset = '0;
      1: c.y_offset = off;
      default: c.y_offset = {{8{off[23]}}, off[23:0]};
    endcase
    if (k == 0) c.y_offset = 32'h8000_0000;
    if (k == 1) c.y_offset = 32'h7FFF_FFFF;
    return c;
  endfunction

  task automatic set_reg(input logic [2:0] idx, input logic [47:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
  endtask

  task automatic apply_cfg(input cfg_t c);
    set_reg(REG_BPP, 48'(c.bytes_per_point));
    set_reg(REG_MSB_FIRST, 48'(c.msb_first));
    set_reg(REG_SIGNED, 48'(c.signed_samples));
    set_reg(REG_POINT_COUNT, 48'(c.point_count));
    set_reg(REG_Y_MULT, c.y_mult);
    set_reg(REG_Y_ZERO, c.y_zero);
    set_reg(REG_Y_OFFSET, 48'(c.y_offset));
    set_reg(REG_X_INCREMENT, c.x_increment);
    @(posedge clk);
    cfg_we <= 1'b0;
    scaler_cfg = c;
    @(negedge clk);
  endtask

  task automatic set_pressure(input int mode);
    case (mode)
      0: begin idle_pct = 0; stall_pct = 0; end
      1: begin idle_pct = 64; stall_pct = 0; end
      2: begin idle_pct = 0; stall_pct = 64; end
      default: begin idle_pct = 38; stall_pct = 38; end
    endcase
  endtask

  // Bytes that complete no result may still be in flight, so keep waiting after the queues have drained.
  task automatic wait_idle();
    while (curve_bytes.size() != 0 || s_axis_tvalid || due_results.size() != 0)
      @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  initial begin
    #5_000_000;
    $display("waveform_block_sample_scaler regression: fail");
    $finish;
  end

  initial begin
    cfg_t c;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    push_byte(8'h00);
    push_text("#0");
    push_text("#:");
    push_text("#1a");
    push_text("#12");
    push_text("#10");
    push_text("#11");
    push_byte(8'h80);
    push_text("X");
    push_text("#11");
    push_byte(8'h7F);
    push_byte(CH_LF);
    push_text("#11");
    push_byte(8'hFF);
    push_byte(CH_LF);
    wait_idle();

    for (int k = 0; k < 10; k++) begin
      set_pressure(k % 4);
      apply_cfg(make_cfg(k));
      bytes_queued = 0;
      while (bytes_queued < 35) push_random_block();
      if (k == 5) wait_idle();
      while (bytes_queued < 70) push_random_block();
      wait_idle();
    end

    // The point count beyond the supported maximum is clamped before the length check.
    c = scaler_cfg;
    c.bytes_per_point = 2'd3;
    c.point_count = '1;
    apply_cfg(c);
    push_header(2097151, 7);
    push_header(1048577, 9);
    push_header(1048575, 7);
    wait_idle();
    repeat (16) @(negedge clk);

    if (mismatch_count == 0 && due_results.size() == 0) begin
      $display("waveform_block_sample_scaler regression: pass");
    end else begin
      $display("waveform_block_sample_scaler regression: fail");
    end
    $finish;
  end

endmodule
